// ----- rtl/stxr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stxr_pkg
// Shared types and constants for the STX frame receiver.
// ----------------------------------------------------------------------------
package stxr_pkg;

    localparam int unsigned CFG_ADDR_W = 4;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_START_CODE = 2'd0,
        REG_END_CODE   = 2'd1,
        REG_ACK_CODE   = 2'd2
    } reg_index_t;

    localparam logic [7:0] START_CODE_RST = 8'd2;
    localparam logic [7:0] END_CODE_RST   = 8'd3;
    localparam logic [7:0] ACK_CODE_RST   = 8'd6;

    typedef enum logic [4:0] {
        PH_HUNT  = 5'b00001,
        PH_LEN   = 5'b00010,
        PH_DATA  = 5'b00100,
        PH_CHECK = 5'b01000,
        PH_END   = 5'b10000
    } phase_t;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic [1:0] ST_VALID    = 2'd0;
    localparam logic [1:0] ST_ZERO_LEN = 2'd1;
    localparam logic [1:0] ST_BAD_SUM  = 2'd2;
    localparam logic [1:0] ST_NO_END   = 2'd3;

    typedef struct packed {
        logic [7:0] start_code;
        logic [7:0] end_code;
        logic [7:0] ack_code;
    } cfg_t;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [1:0] frame_status;
        logic [7:0] frame_length;
        logic [7:0] reply_byte;
        logic       send_reply;
    } result_t;

endpackage
`default_nettype wire

// ----- rtl/stxr_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stxr_cfg_regs
// APB register file holding the start, end and acknowledge codes.
// ----------------------------------------------------------------------------
module stxr_cfg_regs (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [stxr_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [stxr_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [stxr_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                   pready,
    output stxr_pkg::cfg_t                         cfg
);
    import stxr_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    reg_index_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_index_t'(paddr[3:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_code <= START_CODE_RST;
            cfg_reg.end_code   <= END_CODE_RST;
            cfg_reg.ack_code   <= ACK_CODE_RST;
        end else if (wr_en) begin
            case (idx)
                REG_START_CODE: cfg_reg.start_code <= pwdata[7:0];
                REG_END_CODE:   cfg_reg.end_code   <= pwdata[7:0];
                REG_ACK_CODE:   cfg_reg.ack_code   <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (idx)
            REG_START_CODE: prdata[7:0] = cfg_reg.start_code;
            REG_END_CODE:   prdata[7:0] = cfg_reg.end_code;
            REG_ACK_CODE:   prdata[7:0] = cfg_reg.ack_code;
            default:        prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/stxr_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stxr_parser
// Frame state machine: one byte step per transfer, builds the result item.
// ----------------------------------------------------------------------------
module stxr_parser (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step,
    input  wire logic [7:0]      rx_byte,
    input  stxr_pkg::cfg_t       cfg,
    output logic                 res_valid,
    output stxr_pkg::result_t    res
);
    import stxr_pkg::*;

    phase_t     phase_reg,   phase_next;
    logic [7:0] exp_len_reg, exp_len_next;
    logic [7:0] taken_reg,   taken_next;
    logic [7:0] sum_reg,     sum_next;
    logic [7:0] check_reg,   check_next;
    logic [7:0] taken_inc;

    assign taken_inc = taken_reg + 8'd1;

    always_comb begin
        phase_next   = phase_reg;
        exp_len_next = exp_len_reg;
        taken_next   = taken_reg;
        sum_next     = sum_reg;
        check_next   = check_reg;
        res_valid    = 1'b0;
        res          = '0;
        case (phase_reg)
            PH_LEN: begin
                exp_len_next = rx_byte;
                if (rx_byte == 8'd0) begin
                    phase_next       = PH_HUNT;
                    res_valid        = 1'b1;
                    res.item_kind    = KIND_STATUS;
                    res.frame_status = ST_ZERO_LEN;
                end else begin
                    taken_next = 8'd0;
                    sum_next   = 8'd0;
                    phase_next = PH_DATA;
                end
            end
            PH_DATA: begin
                res_valid         = 1'b1;
                res.item_kind     = KIND_PAYLOAD;
                res.payload_byte  = rx_byte;
                res.payload_index = taken_reg;
                sum_next          = sum_reg + rx_byte;
                taken_next        = taken_inc;
                if (taken_inc == exp_len_reg) begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK: begin
                check_next = rx_byte;
                phase_next = PH_END;
            end
            PH_END: begin
                phase_next       = PH_HUNT;
                res_valid        = 1'b1;
                res.item_kind    = KIND_STATUS;
                res.frame_length = exp_len_reg;
                if (check_reg != sum_reg) begin
                    res.frame_status = ST_BAD_SUM;
                end else if (rx_byte != cfg.end_code) begin
                    res.frame_status = ST_NO_END;
                end else begin
                    res.frame_status = ST_VALID;
                    res.reply_byte   = cfg.ack_code;
                    res.send_reply   = 1'b1;
                end
            end
            default: begin
                phase_next = (rx_byte == cfg.start_code) ? PH_LEN : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            exp_len_reg <= 8'd0;
            taken_reg   <= 8'd0;
            sum_reg     <= 8'd0;
            check_reg   <= 8'd0;
        end else if (step) begin
            phase_reg   <= phase_next;
            exp_len_reg <= exp_len_next;
            taken_reg   <= taken_next;
            sum_reg     <= sum_next;
            check_reg   <= check_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/stx_frame_receiver.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A result is registered and appears in the cycle after its byte is transferred.
// Throughput: one byte per cycle; the only holding element is the result register.
// A byte is taken while the result register is empty or being drained.
// Reset (aresetn low, synchronous) returns to start-byte hunt and restores the
// default codes (start 0x02, end 0x03, ack 0x06).
// ----------------------------------------------------------------------------
// stx_frame_receiver
// Byte-stream frame receiver: START, LEN, payload, CHECK, END.
// ----------------------------------------------------------------------------
module stx_frame_receiver (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [stxr_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [stxr_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [stxr_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                   pready,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [7:0]                        s_rx_byte,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_item_kind,
    output logic      [7:0]                        m_payload_byte,
    output logic      [7:0]                        m_payload_index,
    output logic      [1:0]                        m_frame_status,
    output logic      [7:0]                        m_frame_length,
    output logic      [7:0]                        m_reply_byte,
    output logic                                   m_send_reply
);
    import stxr_pkg::*;

    cfg_t    cfg;
    result_t res;
    result_t out_reg;
    logic    res_valid;
    logic    step;
    logic    out_valid_reg;

    assign s_ready = !out_valid_reg || m_ready;
    assign step    = s_valid && s_ready;

    stxr_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    stxr_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .rx_byte   (s_rx_byte),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_ready) begin
            out_valid_reg <= step && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_item_kind     = out_reg.item_kind;
    assign m_payload_byte  = out_reg.payload_byte;
    assign m_payload_index = out_reg.payload_index;
    assign m_frame_status  = out_reg.frame_status;
    assign m_frame_length  = out_reg.frame_length;
    assign m_reply_byte    = out_reg.reply_byte;
    assign m_send_reply    = out_reg.send_reply;

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while result stalled");

    a_reply_only_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_send_reply) |->
            (m_item_kind == KIND_STATUS && m_frame_status == ST_VALID))
        else $error("reply requested on non-valid frame status");

    a_payload_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item_kind == KIND_PAYLOAD) |->
            (m_frame_status == ST_VALID && m_frame_length == 8'd0 && !m_send_reply))
        else $error("payload transfer carries status fields");
`endif

endmodule
`default_nettype wire
